>>> src/mff_pkg.sv
// Shared types, frame control constants and field helpers for the
// 802.15.4 receive frame filter. Used by mff_decide and the top level.
package mff_pkg;

    // frame control bits
    localparam logic [15:0] FC_TYPE_MASK    = 16'h0007;
    localparam logic [15:0] FC_TYPE_BEACON  = 16'h0000;
    localparam logic [15:0] FC_TYPE_DATA    = 16'h0001;
    localparam logic [15:0] FC_TYPE_COMMAND = 16'h0003;
    localparam logic [15:0] FC_SECURITY     = 16'h0008;
    localparam logic [15:0] FC_ACK_REQUEST  = 16'h0020;
    localparam logic [15:0] FC_PAN_COMPRESS = 16'h0040;
    localparam logic [15:0] FC_SEQ_SUPPRESS = 16'h0100;
    localparam logic [15:0] FC_DST_LONG     = 16'h0400;
    localparam logic [15:0] FC_DST_PRESENT  = 16'h0800;
    localparam logic [15:0] FC_SRC_LONG     = 16'h4000;
    localparam logic [15:0] FC_SRC_PRESENT  = 16'h8000;

    localparam logic [7:0]  CMD_DATA_REQUEST = 8'h04;
    localparam logic [15:0] BROADCAST        = 16'hffff;
    localparam logic [7:0]  SIFS_MAX_LENGTH  = 8'd18;
    localparam logic [7:0]  MAX_FRAME_LENGTH = 8'd127;

    // context flag bit positions inside flags[5:0]
    localparam int CF_ALL        = 0;
    localparam int CF_BEACON     = 1;
    localparam int CF_DEST_SHORT = 2;
    localparam int CF_DATA_SHORT = 3;
    localparam int CF_DEST_LONG  = 4;
    localparam int CF_HANDLE_ACK = 5;

    // configuration register indexes
    localparam logic [2:0] REG_LONG_ADDRESS = 3'd0;
    localparam logic [2:0] REG_CONTEXT_0    = 3'd1;
    localparam logic [2:0] REG_CONTEXT_LAST = 3'd4;

    localparam int CTX_WIDTH = 38;

    typedef logic [CTX_WIDTH-1:0] context_t;

    // captured header fields of the frame including the current byte
    typedef struct packed {
        logic [7:0]  length;
        logic [15:0] fc;
        logic [7:0]  seq;
        logic [15:0] pan;
        logic [63:0] dst;
        logic [7:0]  cmd;
        logic [8:0]  count;
        logic        crc_good;
    } frame_t;

    // one filter result
    typedef struct packed {
        logic       frame_ok;
        logic       long_gap;
        logic       poll_request;
        logic [7:0] ack_sequence;
        logic       ack_needed;
        logic [3:0] pass_mask;
    } result_t;

    // destination address length in bytes
    function automatic logic [3:0] dest_len(input logic [15:0] fc);
        logic [3:0] len;
        if ((fc & FC_DST_PRESENT) == 16'h0)
            len = 4'd0;
        else if ((fc & FC_DST_LONG) != 16'h0)
            len = 4'd8;
        else
            len = 4'd2;
        return len;
    endfunction

    // byte position of the command identifier
    function automatic logic [4:0] command_pos(input logic [15:0] fc);
        logic [4:0] src;
        src = ((fc & FC_SRC_LONG) != 16'h0) ? 5'd8 : 5'd2;
        return 5'd6 + {1'b0, dest_len(fc)} + src;
    endfunction

endpackage

>>> src/mac_frame_filter_autoack.sv
// 802.15.4 receive frame filter with auto-ack decision, stream in and out.
// A result is taken into the result register from the tlast beat held in the
// input register. Throughput: one byte beat per cycle, but a tlast beat waits
// while a result is held untaken; field capture and decision are combinational.
// Reset (rst_n low, asynchronous): configuration and frame state clear to
// zero, both pipeline registers empty. Depends on mff_pkg and mff_decide.
module mac_frame_filter_autoack #(
    parameter int CONTEXT_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    input  logic        s_axis_tuser,   // [0] crc_good
    // filter results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [3:0] pass_mask, [4] ack_needed,
                                        // [12:5] ack_sequence, [13] poll_request,
                                        // [14] long_gap, [15] frame_ok
);

    // configuration registers
    logic [63:0]       long_address_reg;
    mff_pkg::context_t context_reg [CONTEXT_COUNT];

    // input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       in_crc_reg;

    // frame capture state
    logic [7:0]  pos_reg,    pos_next;
    logic [7:0]  length_reg, length_next;
    logic [15:0] fc_reg,     fc_next;
    logic [7:0]  seq_reg,    seq_next;
    logic [15:0] pan_reg,    pan_next;
    logic [63:0] dst_reg,    dst_next;
    logic [7:0]  cmd_reg,    cmd_next;

    // output register
    logic             out_valid_reg;
    mff_pkg::result_t out_data_reg;

    logic             out_free;
    logic             consume;
    logic [7:0]       dst_off;
    mff_pkg::frame_t  frame;
    mff_pkg::result_t result;

    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign consume       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || consume;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_address_reg <= 64'd0;
            for (int i = 0; i < CONTEXT_COUNT; i++)
                context_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == mff_pkg::REG_LONG_ADDRESS)
                long_address_reg <= cfg_data;
            for (int i = 0; i < CONTEXT_COUNT; i++)
                if (cfg_index == mff_pkg::REG_CONTEXT_0 + 3'(i) &&
                    cfg_index <= mff_pkg::REG_CONTEXT_LAST)
                    context_reg[i] <= cfg_data[mff_pkg::CTX_WIDTH-1:0];
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
            in_crc_reg  <= s_axis_tuser;
        end
    end

    // field capture at fixed byte positions, the command byte where fc places it
    always_comb
    begin
        length_next = length_reg;
        fc_next     = fc_reg;
        seq_next    = seq_reg;
        pan_next    = pan_reg;
        dst_next    = dst_reg;
        cmd_next    = cmd_reg;
        dst_off     = pos_reg - 8'd6;
        case (pos_reg)
            8'd0: length_next = in_data_reg;
            8'd1: fc_next[7:0] = in_data_reg;
            8'd2: fc_next[15:8] = in_data_reg;
            8'd3: seq_next = in_data_reg;
            8'd4: pan_next[7:0] = in_data_reg;
            8'd5: pan_next[15:8] = in_data_reg;
            default:
            begin
                if (pos_reg <= 8'd13)
                    dst_next[{dst_off[2:0], 3'b000} +: 8] = in_data_reg;
            end
        endcase
        if (pos_reg >= 8'd3 && pos_reg == {3'd0, mff_pkg::command_pos(fc_next)})
            cmd_next = in_data_reg;
        pos_next = (pos_reg == 8'hff) ? pos_reg : pos_reg + 8'd1;
    end

    always_comb
    begin
        frame.length   = length_next;
        frame.fc       = fc_next;
        frame.seq      = seq_next;
        frame.pan      = pan_next;
        frame.dst      = dst_next;
        frame.cmd      = cmd_next;
        frame.count    = {1'b0, pos_reg} + 9'd1;
        frame.crc_good = in_crc_reg;
    end

    mff_decide #(
        .CONTEXT_COUNT(CONTEXT_COUNT)
    ) u_decide (
        .frame       (frame),
        .long_address(long_address_reg),
        .contexts    (context_reg),
        .result      (result)
    );

    // frame state: advance per byte, clear after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            length_reg <= 8'd0;
            fc_reg     <= 16'd0;
            seq_reg    <= 8'd0;
            pan_reg    <= 16'd0;
            dst_reg    <= 64'd0;
            cmd_reg    <= 8'd0;
        end
        else if (consume)
        begin
            if (in_last_reg)
            begin
                pos_reg    <= 8'd0;
                length_reg <= 8'd0;
                fc_reg     <= 16'd0;
                seq_reg    <= 8'd0;
                pan_reg    <= 16'd0;
                dst_reg    <= 64'd0;
                cmd_reg    <= 8'd0;
            end
            else
            begin
                pos_reg    <= pos_next;
                length_reg <= length_next;
                fc_reg     <= fc_next;
                seq_reg    <= seq_next;
                pan_reg    <= pan_next;
                dst_reg    <= dst_next;
                cmd_reg    <= cmd_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (consume && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (consume && in_last_reg)
            out_data_reg <= result;
    end

endmodule

>>> src/mff_decide.sv
// Per-context accept decision, auto-ack and data-request evaluation.
// Depends on mff_pkg for field types and frame control constants.
module mff_decide #(
    parameter int CONTEXT_COUNT = 4
) (
    input  mff_pkg::frame_t   frame,
    input  logic [63:0]       long_address,
    input  mff_pkg::context_t contexts [CONTEXT_COUNT],
    output mff_pkg::result_t  result
);

    // does one context accept the frame (address and type rules only)
    function automatic logic accepts(input mff_pkg::context_t ctx,
                                     input mff_pkg::frame_t f,
                                     input logic [63:0] own_long);
        logic [5:0]  flags;
        logic [15:0] pan;
        logic [15:0] saddr;
        logic [15:0] ftype;
        logic        ok;
        flags = ctx[37:32];
        pan   = ctx[15:0];
        saddr = ctx[31:16];
        ftype = f.fc & mff_pkg::FC_TYPE_MASK;
        ok    = 1'b0;
        if (flags[mff_pkg::CF_ALL])
            ok = 1'b1;
        else if ((f.fc & mff_pkg::FC_SEQ_SUPPRESS) != 16'h0)
            ok = 1'b0;
        else if (flags[mff_pkg::CF_BEACON] && ftype == mff_pkg::FC_TYPE_BEACON)
            ok = 1'b1;
        else if ((f.fc & mff_pkg::FC_DST_PRESENT) == 16'h0)
            ok = 1'b0;
        else if (f.pan != mff_pkg::BROADCAST && f.pan != pan)
            ok = 1'b0;
        else if ((f.fc & mff_pkg::FC_DST_LONG) == 16'h0)
        begin
            if (flags[mff_pkg::CF_DEST_SHORT] ||
                (flags[mff_pkg::CF_DATA_SHORT] && ftype == mff_pkg::FC_TYPE_DATA))
                ok = (f.dst[15:0] == mff_pkg::BROADCAST) || (f.dst[15:0] == saddr);
        end
        else
            ok = flags[mff_pkg::CF_DEST_LONG] && (f.dst == own_long);
        return ok;
    endfunction

    localparam logic [15:0] DREQ_MASK = mff_pkg::FC_TYPE_MASK | mff_pkg::FC_SECURITY |
        mff_pkg::FC_PAN_COMPRESS | mff_pkg::FC_SEQ_SUPPRESS | mff_pkg::FC_DST_PRESENT |
        mff_pkg::FC_SRC_PRESENT;
    localparam logic [15:0] DREQ_FORM = mff_pkg::FC_TYPE_COMMAND | mff_pkg::FC_PAN_COMPRESS |
        mff_pkg::FC_DST_PRESENT | mff_pkg::FC_SRC_PRESENT;

    logic [8:0] need;
    logic       len_ok;
    logic       cmd_seen;
    logic       dreq_frame;
    logic [3:0] pass;
    logic       ack;
    logic       dreq;
    logic [5:0] flags;

    // frame-wide qualifiers
    always_comb
    begin
        if ((frame.fc & mff_pkg::FC_DST_PRESENT) != 16'h0)
            need = 9'd6 + {5'd0, mff_pkg::dest_len(frame.fc)};
        else
            need = 9'd4;
        len_ok     = frame.crc_good && (frame.count >= need) &&
                     (frame.length <= mff_pkg::MAX_FRAME_LENGTH);
        cmd_seen   = frame.count > {4'd0, mff_pkg::command_pos(frame.fc)};
        dreq_frame = ((frame.fc & DREQ_MASK) == DREQ_FORM) && cmd_seen &&
                     (frame.cmd == mff_pkg::CMD_DATA_REQUEST);
    end

    // per-context evaluation, independent lanes
    always_comb
    begin
        pass  = 4'd0;
        ack   = 1'b0;
        dreq  = 1'b0;
        flags = 6'd0;
        for (int i = 0; i < CONTEXT_COUNT; i++)
        begin
            flags = contexts[i][37:32];
            if (len_ok && flags != 6'd0 && accepts(contexts[i], frame, long_address))
            begin
                pass[i] = 1'b1;
                if (flags[mff_pkg::CF_HANDLE_ACK] &&
                    (frame.fc & mff_pkg::FC_ACK_REQUEST) != 16'h0)
                begin
                    ack = 1'b1;
                    if (dreq_frame)
                    begin
                        dreq    = 1'b1;
                        pass[i] = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        result.pass_mask    = pass;
        result.ack_needed   = ack;
        result.ack_sequence = ack ? frame.seq : 8'd0;
        result.poll_request = dreq;
        result.long_gap     = !frame.crc_good || (frame.length > mff_pkg::SIFS_MAX_LENGTH);
        result.frame_ok     = frame.crc_good;
    end

endmodule

>>> src/mff_checker.sv
// Port-level checks for mac_frame_filter_autoack, attached by bind.
// Sees only the top-level ports; no package dependency.
module mff_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result beat stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // CRC error: nothing passes, no ack, no data request, long gap
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[15] |->
            m_axis_tdata[3:0] == 4'd0 && !m_axis_tdata[4] && !m_axis_tdata[13] &&
            m_axis_tdata[14])
        else $error("bad CRC frame not rejected");

    // the sequence number is only reported with an ack
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[12:5] == 8'd0)
        else $error("ack sequence without ack");

    // a data request is only flagged by an ack-handling context
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tdata[4])
        else $error("data request without ack");

endmodule

bind mac_frame_filter_autoack mff_checker u_mff_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

>>> dv/tb_top.sv
// Self-checking testbench for the 802.15.4 receive frame filter with auto-ack.
// Streams random and directed frames through mac_frame_filter_autoack and checks
// every result against a cycle-free predictor. Depends on mff_pkg and the RTL.
module tb_top;

    localparam int PHASES         = 8;
    localparam int PHASE_BYTES    = 220;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_AFTER     = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int LONG_PHASE     = 3;

    // frame control pattern of a data-request command
    localparam logic [15:0] DREQ_MASK = mff_pkg::FC_TYPE_MASK | mff_pkg::FC_SECURITY |
        mff_pkg::FC_PAN_COMPRESS | mff_pkg::FC_SEQ_SUPPRESS | mff_pkg::FC_DST_PRESENT |
        mff_pkg::FC_SRC_PRESENT;
    localparam logic [15:0] DREQ_FORM = mff_pkg::FC_TYPE_COMMAND | mff_pkg::FC_PAN_COMPRESS |
        mff_pkg::FC_DST_PRESENT | mff_pkg::FC_SRC_PRESENT;

    // predicts filter results from accepted byte beats and checks the output
    class filter_scoreboard;
        logic [63:0]       own_long;
        mff_pkg::context_t ctx[4];
        logic [7:0]        pos;
        logic [7:0]        flen;
        logic [15:0]       fc;
        logic [7:0]        seq;
        logic [15:0]       pan;
        logic [63:0]       dst;
        logic [7:0]        cmd;
        mff_pkg::result_t  pending[$];
        int                mismatches;
        int                checked;
        int                acks;
        int                dreqs;
        int                crc_errors;
        int                passed;

        function new();
            own_long = '0;
            foreach (ctx[i]) ctx[i] = '0;
            mismatches = 0;
            checked = 0;
            acks = 0;
            dreqs = 0;
            crc_errors = 0;
            passed = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos = '0;
            flen = '0;
            fc = '0;
            seq = '0;
            pan = '0;
            dst = '0;
            cmd = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] v);
            if (idx == mff_pkg::REG_LONG_ADDRESS)
                own_long = v;
            else if (idx <= mff_pkg::REG_CONTEXT_LAST)
                ctx[idx - mff_pkg::REG_CONTEXT_0] = v[mff_pkg::CTX_WIDTH-1:0];
        endfunction

        function int dst_bytes(logic [15:0] f);
            if ((f & mff_pkg::FC_DST_PRESENT) == 16'h0)
                return 0;
            return ((f & mff_pkg::FC_DST_LONG) != 16'h0) ? 8 : 2;
        endfunction

        function int cmd_offset(logic [15:0] f);
            return 6 + dst_bytes(f) + (((f & mff_pkg::FC_SRC_LONG) != 16'h0) ? 8 : 2);
        endfunction

        // address match of one context against the captured header
        function bit ctx_accepts(mff_pkg::context_t c);
            logic [5:0]  fl;
            logic [15:0] typ;
            fl = c[37:32];
            typ = fc & mff_pkg::FC_TYPE_MASK;
            if (fl[mff_pkg::CF_ALL])
                return 1'b1;
            if ((fc & mff_pkg::FC_SEQ_SUPPRESS) != 16'h0)
                return 1'b0;
            if (fl[mff_pkg::CF_BEACON] && typ == mff_pkg::FC_TYPE_BEACON)
                return 1'b1;
            if ((fc & mff_pkg::FC_DST_PRESENT) == 16'h0)
                return 1'b0;
            if (pan != mff_pkg::BROADCAST && pan != c[15:0])
                return 1'b0;
            if ((fc & mff_pkg::FC_DST_LONG) == 16'h0)
            begin
                if (fl[mff_pkg::CF_DEST_SHORT] ||
                    (fl[mff_pkg::CF_DATA_SHORT] && typ == mff_pkg::FC_TYPE_DATA))
                begin
                    if (dst[15:0] == mff_pkg::BROADCAST || dst[15:0] == c[31:16])
                        return 1'b1;
                end
                return 1'b0;
            end
            return fl[mff_pkg::CF_DEST_LONG] && dst == own_long;
        endfunction

        // capture one accepted byte beat; a tlast beat yields one expectation
        function void note_byte(logic [7:0] d, logic last, logic crc);
            int               p;
            int               count;
            int               need;
            bit               ack;
            bit               dreq;
            bit               cmd_seen;
            logic [3:0]       pass;
            logic [5:0]       fl;
            mff_pkg::result_t r;
            p = pos;
            if (p == 0)
                flen = d;
            else if (p == 1)
                fc[7:0] = d;
            else if (p == 2)
                fc[15:8] = d;
            else if (p == 3)
                seq = d;
            else if (p == 4)
                pan[7:0] = d;
            else if (p == 5)
                pan[15:8] = d;
            else if (p <= 13)
                dst[(p-6)*8 +: 8] = d;
            if (p >= 3 && p == cmd_offset(fc))
                cmd = d;

            if (!last)
            begin
                if (p < 255)
                    pos = pos + 8'd1;
                return;
            end

            count = p + 1;
            need = ((fc & mff_pkg::FC_DST_PRESENT) != 16'h0) ? 6 + dst_bytes(fc) : 4;
            cmd_seen = count > cmd_offset(fc);
            pass = '0;
            ack = 1'b0;
            dreq = 1'b0;
            if (crc && count >= need && flen <= mff_pkg::MAX_FRAME_LENGTH)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    fl = ctx[i][37:32];
                    if (fl == 6'h0 || !ctx_accepts(ctx[i]))
                        continue;
                    pass[i] = 1'b1;
                    if (fl[mff_pkg::CF_HANDLE_ACK] && (fc & mff_pkg::FC_ACK_REQUEST) != 16'h0)
                    begin
                        ack = 1'b1;
                        // data request: command with compressed PAN, both addresses
                        if ((fc & DREQ_MASK) == DREQ_FORM && cmd_seen &&
                            cmd == mff_pkg::CMD_DATA_REQUEST)
                        begin
                            dreq = 1'b1;
                            pass[i] = 1'b0;
                        end
                    end
                end
            end

            r.pass_mask = pass;
            r.ack_needed = ack;
            r.ack_sequence = ack ? seq : 8'h00;
            r.poll_request = dreq;
            r.long_gap = !crc || flen > mff_pkg::SIFS_MAX_LENGTH;
            r.frame_ok = crc;
            pending.push_back(r);
            acks += ack;
            dreqs += dreq;
            crc_errors += !crc;
            passed += (pass != 4'h0);
            clear_frame();
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic [15:0] raw);
            mff_pkg::result_t got;
            mff_pkg::result_t want;
            bit               bad;
            got = raw;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result %h with no frame pending", raw);
                return;
            end
            want = pending.pop_front();
            bad = (got.pass_mask !== want.pass_mask) ||
                  (got.ack_needed !== want.ack_needed) ||
                  (got.ack_sequence !== want.ack_sequence) ||
                  (got.poll_request !== want.poll_request) ||
                  (got.long_gap !== want.long_gap) ||
                  (got.frame_ok !== want.frame_ok);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("ERROR: result %0d expected pass=%h ack=%b seq=%h dreq=%b gap=%b ok=%b",
                             checked, want.pass_mask, want.ack_needed, want.ack_sequence,
                             want.poll_request, want.long_gap, want.frame_ok);
                    $display("       got pass=%h ack=%b seq=%h dreq=%b gap=%b ok=%b",
                             got.pass_mask, got.ack_needed, got.ack_sequence,
                             got.poll_request, got.long_gap, got.frame_ok);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;  // last_byte
    logic        s_axis_tuser = 1'b0;  // [0] crc_good
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [3:0] pass_mask, [4] ack_needed,
                                       // [12:5] ack_sequence, [13] poll_request,
                                       // [14] long_gap, [15] frame_ok

    filter_scoreboard  sb;
    logic [7:0]        frame_q[$];
    logic [63:0]       set_long;
    mff_pkg::context_t set_ctx[4];
    int                bytes_sent = 0;
    int                settings_count = 0;
    int                idle_cycles = 0;

    mac_frame_filter_autoack u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser);
            if ((cfg_valid && cfg_ready) || (m_axis_tvalid && m_axis_tready) ||
                (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result receiver: random stalls, calm stretches and one long hold-off
    initial
    begin : result_sink
        int stall_left;
        int calm_left;
        int r;
        bit hold_done;
        stall_left = 0;
        calm_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            // start the hold-off while the sender is offering bytes
            if (!hold_done && sb.checked >= HOLD_AFTER && s_axis_tvalid)
            begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    calm_left = $urandom_range(20, 80);
                else if (r < 30)
                    stall_left = $urandom_range(0, 2);
                else if (r < 33)
                    stall_left = $urandom_range(8, 40);
                m_axis_tready <= (r >= 8 && r < 33) ? 1'b0 : 1'b1;
            end
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 0;
        if (r < 97)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one byte beat; tvalid stays high into the next beat unless a gap follows
    task automatic send_byte(input logic [7:0] d, input logic l, input logic c,
                             input bit no_gaps);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tlast <= l;
        s_axis_tuser <= c;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
        gap = no_gaps ? 0 : sender_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame(input logic crc_final);
        bit no_gaps;
        bit l;
        no_gaps = $urandom_range(0, 99) < 30;
        for (int i = 0; i < frame_q.size(); i++)
        begin
            l = (i == frame_q.size() - 1);
            send_byte(frame_q[i], l, l ? crc_final : logic'($urandom_range(0, 1)), no_gaps);
        end
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        // let the monitor note the final byte first
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // all registers plus one index past the list, which must be ignored
    task automatic program_settings();
        write_reg(mff_pkg::REG_LONG_ADDRESS, set_long);
        for (int i = 0; i < 4; i++)
            write_reg(mff_pkg::REG_CONTEXT_0 + 3'(i), 64'(set_ctx[i]));
        write_reg(mff_pkg::REG_CONTEXT_LAST + 3'($urandom_range(1, 3)), {$urandom, $urandom});
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    function automatic mff_pkg::context_t random_context();
        logic [15:0] p;
        logic [15:0] a;
        logic [5:0]  fl;
        int          r;
        r = $urandom_range(0, 99);
        p = (r < 15) ? mff_pkg::BROADCAST : (r < 25) ? 16'h0000 : 16'($urandom);
        r = $urandom_range(0, 99);
        a = (r < 10) ? mff_pkg::BROADCAST : (r < 20) ? 16'h0000 : 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 12)
            fl = 6'h00;
        else if (r < 22)
            fl = 6'h3f;
        else
        begin
            fl = 6'($urandom_range(1, 63));
            if ($urandom_range(0, 99) < 70)
                fl[mff_pkg::CF_ALL] = 1'b0;
        end
        return {fl, a, p};
    endfunction

    task automatic pick_settings(input int ph);
        int r;
        if (ph == 0)
        begin
            set_long = '1;
            foreach (set_ctx[i]) set_ctx[i] = '1;
        end
        else if (ph == 1)
        begin
            set_long = '0;
            foreach (set_ctx[i]) set_ctx[i] = '0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            set_long = (r < 15) ? 64'h0 : (r < 30) ? '1 : {$urandom, $urandom};
            foreach (set_ctx[i]) set_ctx[i] = random_context();
        end
    endtask

    // set or clear the frame control bits in m, set with the given percentage
    function automatic logic [15:0] fc_pick(input logic [15:0] f, input logic [15:0] m,
                                            input int pct);
        return ($urandom_range(0, 99) < pct) ? (f | m) : (f & ~m);
    endfunction

    // random frame: mostly well formed headers aimed at the live contexts
    task automatic build_frame(input bit force_long);
        int          kind;
        int          n;
        int          c;
        int          r;
        logic [15:0] f;
        logic [15:0] p;
        logic [15:0] a;
        logic [63:0] la;
        frame_q.delete();
        kind = force_long ? 0 : $urandom_range(0, 199);
        if (kind < 3)
        begin
            n = $urandom_range(128, 270);
            repeat (n) frame_q.push_back(8'($urandom));
            return;
        end
        if (kind < 30)
        begin
            n = $urandom_range(1, 20);
            repeat (n) frame_q.push_back(8'($urandom));
            return;
        end
        f = 16'($urandom);
        r = $urandom_range(0, 3);
        if (r == 0)
            f = (f & ~mff_pkg::FC_TYPE_MASK) | mff_pkg::FC_TYPE_BEACON;
        else if (r == 1)
            f = (f & ~mff_pkg::FC_TYPE_MASK) | mff_pkg::FC_TYPE_DATA;
        else if (r == 2)
            f = (f & ~mff_pkg::FC_TYPE_MASK) | mff_pkg::FC_TYPE_COMMAND;
        f = fc_pick(f, mff_pkg::FC_ACK_REQUEST, 60);
        f = fc_pick(f, mff_pkg::FC_SECURITY, 10);
        f = fc_pick(f, mff_pkg::FC_PAN_COMPRESS, 70);
        f = fc_pick(f, mff_pkg::FC_SEQ_SUPPRESS, 8);
        f = fc_pick(f, mff_pkg::FC_DST_PRESENT, 85);
        f = fc_pick(f, mff_pkg::FC_DST_LONG, 30);
        f = fc_pick(f, mff_pkg::FC_SRC_PRESENT, 80);
        f = fc_pick(f, mff_pkg::FC_SRC_LONG, 30);
        if ($urandom_range(0, 99) < 20)
            f = DREQ_FORM | mff_pkg::FC_ACK_REQUEST |
                (f & (mff_pkg::FC_DST_LONG | mff_pkg::FC_SRC_LONG));
        c = $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        p = (r < 70) ? set_ctx[c][15:0] : (r < 85) ? mff_pkg::BROADCAST : 16'($urandom);
        frame_q.push_back(8'h00);
        frame_q.push_back(f[7:0]);
        frame_q.push_back(f[15:8]);
        frame_q.push_back(8'($urandom));
        frame_q.push_back(p[7:0]);
        frame_q.push_back(p[15:8]);
        r = $urandom_range(0, 99);
        if ((f & mff_pkg::FC_DST_LONG) != 16'h0)
        begin
            la = (r < 60) ? set_long :
                 (r < 80) ? set_long ^ (64'h1 << $urandom_range(0, 63)) : {$urandom, $urandom};
            for (int i = 0; i < 8; i++)
                frame_q.push_back(la[i*8 +: 8]);
        end
        else
        begin
            a = (r < 60) ? set_ctx[c][31:16] : (r < 80) ? mff_pkg::BROADCAST : 16'($urandom);
            frame_q.push_back(a[7:0]);
            frame_q.push_back(a[15:8]);
        end
        // source address bytes, then the command byte
        repeat (((f & mff_pkg::FC_SRC_LONG) != 16'h0) ? 8 : 2)
            frame_q.push_back(8'($urandom));
        frame_q.push_back(($urandom_range(0, 99) < 60) ? mff_pkg::CMD_DATA_REQUEST :
                                                         8'($urandom));
        repeat ($urandom_range(0, 6) + 2) frame_q.push_back(8'($urandom));
        if ($urandom_range(0, 99) < 12)
        begin
            n = $urandom_range(1, frame_q.size());
            while (frame_q.size() > n)
                void'(frame_q.pop_back());
        end
        r = $urandom_range(0, 99);
        frame_q[0] = (r < 80) ? 8'(frame_q.size() - 1) :
                     (r < 90) ? 8'($urandom_range(128, 255)) : 8'($urandom);
    endtask

    initial
    begin
        int target;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: ack handler, beacon passer, long-address handler, pass-all
        set_long = 64'h0123_4567_89ab_cdef;
        set_ctx[0] = {6'b100100, 16'h0001, 16'h1234};
        set_ctx[1] = {6'b000010, 16'h5555, 16'h4321};
        set_ctx[2] = {6'b110000, 16'h0002, 16'h1234};
        set_ctx[3] = {6'b000001, 16'h0000, 16'h0000};
        program_settings();

        // cut short after the length byte
        frame_q = '{8'h00};
        send_frame(1'b1);
        // data request command with ack request and compressed PAN
        frame_q = '{8'h0c, 8'h63, 8'h88, 8'ha5, 8'h34, 8'h12, 8'h01, 8'h00,
                    8'h02, 8'h00, mff_pkg::CMD_DATA_REQUEST};
        send_frame(1'b1);
        // beacon with a CRC error
        frame_q = '{8'h05, 8'h00, 8'h00, 8'h7e};
        send_frame(1'b0);
        // broadcast data frame with an overlong length byte
        frame_q = '{8'hff, 8'h21, 8'h08, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff};
        send_frame(1'b1);
        drain();

        // random phases, each under its own register settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            pick_settings(ph);
            program_settings();
            target = bytes_sent + PHASE_BYTES;
            if (ph == LONG_PHASE)
            begin
                build_frame(1'b1);
                send_frame(1'b1);
            end
            while (bytes_sent < target)
            begin
                build_frame(1'b0);
                send_frame($urandom_range(0, 99) < 80);
            end
            drain();
        end

        if (sb.pending.size() != 0)
            $display("ERROR: %0d results never arrived", sb.pending.size());
        $display("Covered %0d byte beats and %0d frames under %0d register settings",
                 bytes_sent, sb.checked, settings_count);
        $display("Frames with a pass: %0d, acks: %0d, data requests: %0d, CRC errors: %0d",
                 sb.passed, sb.acks, sb.dreqs, sb.crc_errors);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
src/mff_pkg.sv
src/mff_decide.sv
src/mac_frame_filter_autoack.sv
src/mff_checker.sv
dv/tb_top.sv
